// ===== rtl/cpg_pkg.sv =====
package cpg_pkg;

  // Chain dimensions.
  localparam int MAX_ARMS    = 8;
  localparam int PHASE_BITS  = 16;
  localparam int LENGTH_BITS = 10;
  localparam int ARM_IDX_W   = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int ARM_CNT_W   = 5;

  // Field widths of the transactions and registers.
  localparam int CMD_W    = 2;
  localparam int CENTER_W = 12;
  localparam int COUNT_W  = 4;
  localparam int STEP_W   = 16;
  localparam int POINT_W  = 15;
  localparam int CFG_IDX_W = 2;

  // Commands carried on the input tuser.
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ZERO = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd2;

  // Register reset values.
  localparam logic [COUNT_W-1:0]  ARM_COUNT_RST = 4'd1;
  localparam logic [CENTER_W-1:0] CENTER_RST    = 12'd500;

  // Rotator arithmetic.
  localparam int CORDIC_STEPS = 16;
  localparam int STAGE_W      = $clog2(CORDIC_STEPS);
  localparam int CORD_W       = 18;
  localparam int CORDIC_START = 19898;
  localparam int PROD_W       = LENGTH_BITS + 1 + CORD_W;
  localparam int ACC_W        = 34;
  localparam int FRAC_BITS    = 15;
  localparam int OUT_MIN      = -16384;
  localparam int OUT_MAX      = 16383;

  // One item travelling down the rotator chain.
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    logic                     flip;
    logic [LENGTH_BITS-1:0]   len;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } cordic_t;

  // Arctangent of 2^-i, in 1/65536 of a turn.
  function automatic logic signed [CORD_W-1:0] atan_turn(input logic [STAGE_W-1:0] i);
    logic signed [CORD_W-1:0] a;
    case (i)
      4'd0:    a = CORD_W'(8192);
      4'd1:    a = CORD_W'(4836);
      4'd2:    a = CORD_W'(2555);
      4'd3:    a = CORD_W'(1297);
      4'd4:    a = CORD_W'(651);
      4'd5:    a = CORD_W'(326);
      4'd6:    a = CORD_W'(163);
      4'd7:    a = CORD_W'(81);
      4'd8:    a = CORD_W'(41);
      4'd9:    a = CORD_W'(20);
      4'd10:   a = CORD_W'(10);
      4'd11:   a = CORD_W'(5);
      4'd12:   a = CORD_W'(3);
      4'd13:   a = CORD_W'(1);
      4'd14:   a = CORD_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round half up out of the fraction and saturate to the point range.
  function automatic logic [POINT_W-1:0] finish_point(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic [POINT_W-1:0]      p;
    r = (acc + ACC_W'(16384)) >>> FRAC_BITS;
    if (r < ACC_W'(OUT_MIN)) begin
      p = POINT_W'(OUT_MIN);
    end else if (r > ACC_W'(OUT_MAX)) begin
      p = POINT_W'(OUT_MAX);
    end else begin
      p = r[POINT_W-1:0];
    end
    return p;
  endfunction

endpackage

// ===== rtl/cpg_cordic_cell.sv =====
module cpg_cordic_cell
  import cpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [STAGE_W-1:0] stage,
  input  cordic_t            cell_in,
  output cordic_t            cell_out
);

  cordic_t cell_r;
  cordic_t cell_nxt;

  // One micro-rotation; the shift and angle follow this cell's place in the row.
  always_comb begin
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic signed [CORD_W-1:0] zs;
    xs = cell_in.x;
    ys = cell_in.y;
    zs = cell_in.z;
    cell_nxt = cell_in;
    if (zs >= 0) begin
      cell_nxt.x = xs - (ys >>> stage);
      cell_nxt.y = ys + (xs >>> stage);
      cell_nxt.z = zs - atan_turn(stage);
    end else begin
      cell_nxt.x = xs + (ys >>> stage);
      cell_nxt.y = ys - (xs >>> stage);
      cell_nxt.z = zs + atan_turn(stage);
    end
  end

  // Hand the result to the next cell every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== rtl/cpg_tip_accum.sv =====
module cpg_tip_accum
  import cpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cordic_t             tip_in,
  input  logic [CENTER_W-1:0] center_x,
  input  logic [CENTER_W-1:0] center_y,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [POINT_W-1:0]  point_x,
  output logic [POINT_W-1:0]  point_y,
  output logic                res_load
);

  logic                     mul_valid_r;
  logic                     mul_first_r;
  logic                     mul_last_r;
  logic                     mul_flip_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;

  logic signed [ACC_W-1:0]  acc_x_r;
  logic signed [ACC_W-1:0]  acc_y_r;
  logic signed [ACC_W-1:0]  acc_x_nxt;
  logic signed [ACC_W-1:0]  acc_y_nxt;
  logic signed [ACC_W-1:0]  base_x;
  logic signed [ACC_W-1:0]  base_y;
  logic                     done_r;

  logic                     out_valid_r;
  logic [POINT_W-1:0]       point_x_r;
  logic [POINT_W-1:0]       point_y_r;

  // Scale the unit vector by the arm length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= tip_in.valid;
    end
    mul_first_r <= tip_in.first;
    mul_last_r  <= tip_in.last;
    mul_flip_r  <= tip_in.flip;
    prod_x_r    <= $signed({1'b0, tip_in.len}) * tip_in.x;
    prod_y_r    <= $signed({1'b0, tip_in.len}) * tip_in.y;
  end

  // The first arm starts from the centre; a folded phase subtracts its product.
  always_comb begin
    base_x = mul_first_r ? $signed(ACC_W'({center_x, {FRAC_BITS{1'b0}}})) : acc_x_r;
    base_y = mul_first_r ? $signed(ACC_W'({center_y, {FRAC_BITS{1'b0}}})) : acc_y_r;
    if (mul_flip_r) begin
      acc_x_nxt = base_x - ACC_W'(prod_x_r);
      acc_y_nxt = base_y - ACC_W'(prod_y_r);
    end else begin
      acc_x_nxt = base_x + ACC_W'(prod_x_r);
      acc_y_nxt = base_y + ACC_W'(prod_y_r);
    end
  end

  assign res_load = done_r && (!out_valid_r || out_ready);

  // Running sum of the chain; it holds the tip until the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (mul_valid_r && mul_last_r) begin
      done_r <= 1'b1;
    end else if (res_load) begin
      done_r <= 1'b0;
    end
    if (mul_valid_r) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  // Output register of the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      point_x_r <= finish_point(acc_x_r);
      point_y_r <= finish_point(acc_y_r);
    end
  end

  assign out_valid = out_valid_r;
  assign point_x   = point_x_r;
  assign point_y   = point_y_r;

endmodule

// ===== rtl/chained_phasor_point_generator_core.sv =====
// Load and zero commands take effect at their transaction and give no result.
// A step command with n arms in use gives its point after its arms have passed the
// issue register, the rotator row and the scale and sum registers; the input is ready
// again from the edge that registers the point, so only one step is walked at a time.
// Arms enter a 16-cell rotator row one per cycle, so n arms set the walk length.
// rst_n is synchronous and active low: arms, phases and control state clear,
// arm_count returns to 1 and the centre to (500, 500).
module chained_phasor_point_generator_core
  import cpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CENTER_W-1:0]  cfg_wdata,
  // Command channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,  // arm_index[2:0], arm_length[12:3], arm_step[28:13]
  input  logic [CMD_W-1:0]     in_tuser,  // command[1:0]
  // Point channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata  // point_x[14:0], point_y[29:15]
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]                 state_r;
  logic [1:0]                 state_nxt;
  logic [ARM_IDX_W-1:0]       issue_idx_r;
  logic [ARM_IDX_W-1:0]       issue_idx_nxt;
  logic [ARM_IDX_W-1:0]       last_idx;
  logic [ARM_CNT_W-1:0]       cnt_eff;

  logic [COUNT_W-1:0]         arm_count_r;
  logic [CENTER_W-1:0]        center_x_r;
  logic [CENTER_W-1:0]        center_y_r;

  logic [LENGTH_BITS-1:0]     arm_len_r   [MAX_ARMS];
  logic [STEP_W-1:0]          arm_step_r  [MAX_ARMS];
  logic [PHASE_BITS-1:0]      arm_phase_r [MAX_ARMS];

  logic [2:0]                 in_arm_index;
  logic [9:0]                 in_arm_length;
  logic [STEP_W-1:0]          in_arm_step;
  logic                       in_acc;
  logic                       do_load;
  logic                       do_step;
  logic                       do_zero;
  logic                       issuing;

  logic [PHASE_BITS+15:0]     phase_wide;
  logic signed [CORD_W-1:0]   z_raw;
  cordic_t                    issue_r;
  cordic_t                    issue_nxt;
  cordic_t                    chain [CORDIC_STEPS+1];

  logic                       res_load;
  logic [POINT_W-1:0]         point_x;
  logic [POINT_W-1:0]         point_y;

  assign in_arm_index  = in_tdata[2:0];
  assign in_arm_length = in_tdata[12:3];
  assign in_arm_step   = in_tdata[28:13];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign do_load   = in_acc && (in_tuser == CMD_LOAD) && (32'(in_arm_index) < MAX_ARMS);
  assign do_step   = in_acc && (in_tuser == CMD_STEP);
  assign do_zero   = in_acc && (in_tuser == CMD_ZERO);
  assign issuing   = (state_r == ST_ISSUE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_count_r <= ARM_COUNT_RST;
      center_x_r  <= CENTER_RST;
      center_y_r  <= CENTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARM_COUNT: arm_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_CENTER_X:  center_x_r  <= cfg_wdata;
        CFG_CENTER_Y:  center_y_r  <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Arms in use: zero counts as one, and the count stops at the chain length.
  always_comb begin
    if (arm_count_r == '0) begin
      cnt_eff = ARM_CNT_W'(1);
    end else if (32'(arm_count_r) > MAX_ARMS) begin
      cnt_eff = ARM_CNT_W'(MAX_ARMS);
    end else begin
      cnt_eff = ARM_CNT_W'(arm_count_r);
    end
    last_idx = ARM_IDX_W'(cnt_eff - ARM_CNT_W'(1));
  end

  // Arm storage: loads, clearing of all phases and the advance of the arm being issued.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_ARMS; j++) begin
      if (!rst_n) begin
        arm_len_r[j]   <= '0;
        arm_step_r[j]  <= '0;
        arm_phase_r[j] <= '0;
      end else if (do_load && (ARM_IDX_W'(in_arm_index) == ARM_IDX_W'(j))) begin
        arm_len_r[j]   <= LENGTH_BITS'(in_arm_length);
        arm_step_r[j]  <= in_arm_step;
        arm_phase_r[j] <= '0;
      end else if (do_zero) begin
        arm_phase_r[j] <= '0;
      end else if (issuing && (issue_idx_r == ARM_IDX_W'(j))) begin
        arm_phase_r[j] <= arm_phase_r[j] + PHASE_BITS'($signed(arm_step_r[j]));
      end
    end
  end

  // Walk sequencer.
  always_comb begin
    state_nxt     = state_r;
    issue_idx_nxt = issue_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (do_step) begin
          state_nxt     = ST_ISSUE;
          issue_idx_nxt = '0;
        end
      end
      ST_ISSUE: begin
        if (issue_idx_r == last_idx) begin
          state_nxt = ST_WAIT;
        end else begin
          issue_idx_nxt = issue_idx_r + ARM_IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_idx_r <= '0;
    end else begin
      state_r     <= state_nxt;
      issue_idx_r <= issue_idx_nxt;
    end
  end

  // Bring the phase to 16 bits and fold it into the half turn around zero.
  always_comb begin
    phase_wide = {arm_phase_r[issue_idx_r], 16'd0};
    z_raw      = CORD_W'($signed(phase_wide[PHASE_BITS+15 -: 16]));
    issue_nxt.valid = issuing;
    issue_nxt.first = (issue_idx_r == '0);
    issue_nxt.last  = (issue_idx_r == last_idx);
    issue_nxt.len   = arm_len_r[issue_idx_r];
    issue_nxt.x     = CORD_W'(CORDIC_START);
    issue_nxt.y     = '0;
    if (z_raw > CORD_W'(16384)) begin
      issue_nxt.z    = z_raw - CORD_W'(32768);
      issue_nxt.flip = 1'b1;
    end else if (z_raw < -CORD_W'(16384)) begin
      issue_nxt.z    = z_raw + CORD_W'(32768);
      issue_nxt.flip = 1'b1;
    end else begin
      issue_nxt.z    = z_raw;
      issue_nxt.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r.valid <= 1'b0;
    end else begin
      issue_r <= issue_nxt;
    end
  end

  // Row of rotator cells, one micro-rotation each.
  assign chain[0] = issue_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    cpg_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage    (STAGE_W'(k)),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  // Scale, sum and round the chain tip.
  cpg_tip_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .tip_in    (chain[CORDIC_STEPS]),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .point_x   (point_x),
    .point_y   (point_y),
    .res_load  (res_load)
  );

  assign out_tdata = {2'b00, point_y, point_x};

`ifndef NO_ASSERTIONS
  // A step transaction starts the walk at the first arm.
  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_STEP) |=>
      (state_r == ST_ISSUE) && (issue_idx_r == '0))
    else $error("step transaction did not start the arm walk");

  // The last arm enters the row exactly when the sequencer stops issuing.
  a_last_issue: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r.valid && issue_r.last |-> (state_r == ST_WAIT))
    else $error("last arm issued while the sequencer kept walking");

  // Rotated arms only leave the row while a walk is open.
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain[CORDIC_STEPS].valid |-> (state_r == ST_ISSUE) || (state_r == ST_WAIT))
    else $error("rotator output with no step in flight");

  // A point is only registered at the end of a walk.
  a_result_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (state_r == ST_WAIT))
    else $error("point registered outside the wait state");
`endif

endmodule

// ===== verif/tb_chained_phasor_point_generator_core.sv =====
module tb_chained_phasor_point_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cpg_pkg::*;

  // Command code that the block does not define; it must be ignored.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int IDLE_CYCLES    = 40;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 120;
  localparam int MAX_PRINTED    = 30;

  typedef struct packed {
    logic [POINT_W-1:0] y;
    logic [POINT_W-1:0] x;
  } point_t;

  // Chain predictor and store of expected tip points.
  class tip_scoreboard;
    bit [COUNT_W-1:0]     arm_count;
    bit [CENTER_W-1:0]    centre_x;
    bit [CENTER_W-1:0]    centre_y;
    bit [LENGTH_BITS-1:0] arm_len [MAX_ARMS];
    bit [STEP_W-1:0]      arm_step [MAX_ARMS];
    bit [PHASE_BITS-1:0]  arm_phase [MAX_ARMS];
    point_t               tip_queue[$];
    int                   errors;
    int                   points_seen;
    int                   cmd_seen [4];

    function new();
      arm_count = ARM_COUNT_RST;
      centre_x  = CENTER_RST;
      centre_y  = CENTER_RST;
      foreach (arm_len[i]) begin
        arm_len[i]   = '0;
        arm_step[i]  = '0;
        arm_phase[i] = '0;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("[%0t] ERROR: %s", $realtime, msg);
      end
    endfunction

    function int pending();
      return tip_queue.size();
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CENTER_W-1:0] value);
      case (idx)
        CFG_ARM_COUNT: arm_count = value[COUNT_W-1:0];
        CFG_CENTER_X:  centre_x  = value;
        CFG_CENTER_Y:  centre_y  = value;
        default: ;
      endcase
    endfunction

    // Round half up out of Q15 and clamp to the point range.
    function bit [POINT_W-1:0] round_sat(longint acc);
      longint v;
      v = (acc + 64'sd16384) >>> FRAC_BITS;
      if (v < OUT_MIN) v = OUT_MIN;
      if (v > OUT_MAX) v = OUT_MAX;
      return v[POINT_W-1:0];
    endfunction

    // Note one accepted command transaction and predict its point, if any.
    function void note_command(bit [CMD_W-1:0] cmd, bit [ARM_IDX_W-1:0] idx,
                               bit [9:0] len, bit [STEP_W-1:0] stp);
      int     atan_tab [CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                          41, 20, 10, 5, 3, 1, 1, 0};
      int     n;
      longint acc_x, acc_y, x, y, z, nx, ny;
      bit     flip;
      point_t tip;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_LOAD: begin
          if (idx < MAX_ARMS) begin
            arm_len[idx]   = len[LENGTH_BITS-1:0];
            arm_step[idx]  = stp;
            arm_phase[idx] = '0;
          end
        end
        CMD_ZERO: begin
          foreach (arm_phase[i]) arm_phase[i] = '0;
        end
        CMD_STEP: begin
          n = arm_count;
          if (n < 1) n = 1;
          if (n > MAX_ARMS) n = MAX_ARMS;
          acc_x = longint'(centre_x) * 32768;
          acc_y = longint'(centre_y) * 32768;
          for (int a = 0; a < n; a++) begin
            // Fold the phase into a half turn around zero, then rotate.
            x    = CORDIC_START;
            y    = 0;
            z    = longint'($signed(arm_phase[a][PHASE_BITS-1 -: 16]));
            flip = 1'b0;
            if (z > 16384) begin
              z    = z - 32768;
              flip = 1'b1;
            end else if (z < -16384) begin
              z    = z + 32768;
              flip = 1'b1;
            end
            for (int k = 0; k < CORDIC_STEPS; k++) begin
              if (z >= 0) begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z  = z - atan_tab[k];
              end else begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z  = z + atan_tab[k];
              end
              x = nx;
              y = ny;
            end
            if (flip) begin
              x = -x;
              y = -y;
            end
            acc_x = acc_x + longint'(arm_len[a]) * x;
            acc_y = acc_y + longint'(arm_len[a]) * y;
            arm_phase[a] = arm_phase[a] + arm_step[a];
          end
          tip.x = round_sat(acc_x);
          tip.y = round_sat(acc_y);
          tip_queue = {tip_queue, tip};
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted point with the oldest expected tip.
    function void check_point(logic [31:0] data);
      point_t tip;
      points_seen++;
      if (tip_queue.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d", $signed(data[14:0]),
                         $signed(data[29:15])));
        return;
      end
      tip = tip_queue.pop_front();
      if (data[14:0] !== tip.x) begin
        report($sformatf("point %0d: point_x %0d, expected %0d", points_seen,
                         $signed(data[14:0]), $signed(tip.x)));
      end
      if (data[29:15] !== tip.y) begin
        report($sformatf("point %0d: point_y %0d, expected %0d", points_seen,
                         $signed(data[29:15]), $signed(tip.y)));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CENTER_W-1:0]  cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;   // arm_index[2:0], arm_length[12:3], arm_step[28:13]
  logic [CMD_W-1:0]     in_tuser;   // command[1:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;  // point_x[14:0], point_y[29:15]

  tip_scoreboard sb = new();
  bit            calm;
  int            hold_left;
  int            quiet_cycles;
  int            settings_used;

  chained_phasor_point_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall length: mostly short, now and then long.
  function int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int r;
    logic [STEP_W-1:0] corners [7] = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                                       16'h0000, 16'h4000, 16'hC000};
    r = $urandom_range(99);
    if (r < 35) return STEP_W'($urandom_range(600)) - STEP_W'(300);
    if (r < 45) return corners[$urandom_range(6)];
    return STEP_W'($urandom_range(16'hFFFF));
  endfunction

  function logic [9:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 10'd1023;
    if (r < 20) return 10'd0;
    return 10'($urandom_range(1023));
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready = 1'b0;
    end else if (!calm && $urandom_range(99) < 25) begin
      hold_left  = pick_len() - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Monitors: configuration writes, accepted commands and accepted points.
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      sb.write_reg(cfg_index, cfg_wdata);
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_command(in_tuser, in_tdata[2:0], in_tdata[12:3], in_tdata[28:13]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_point(out_tdata);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("chained_phasor_point_generator_core: mismatch");
      $finish;
    end
  end

  // Send one command transaction, then an optional gap. Called at a falling edge.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [2:0] idx,
                      input logic [9:0] len, input logic [STEP_W-1:0] stp);
    int gap;
    in_tuser  = cmd;
    in_tdata  = {3'b000, stp, len, idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    gap = (calm || $urandom_range(99) < 55) ? 0 : pick_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all three registers once the block has gone idle.
  task automatic configure(input int count, input int cx, input int cy);
    drain();
    repeat (IDLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_ARM_COUNT;
    cfg_wdata = CENTER_W'(count);
    @(negedge clk);
    cfg_index = CFG_CENTER_X;
    cfg_wdata = CENTER_W'(cx);
    @(negedge clk);
    cfg_index = CFG_CENTER_Y;
    cfg_wdata = CENTER_W'(cy);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  initial begin
    int count, cx, cy, done, r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    hold_left    = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: reset chain, quarter-turn folding, unused arm, unknown command.
    send(CMD_STEP, 3'd0, 10'd0, 16'h0000);
    send(CMD_LOAD, 3'd0, 10'd1023, 16'h4000);
    repeat (5) send(CMD_STEP, 3'd0, 10'd0, 16'h0000);
    send(CMD_LOAD, 3'd1, 10'd1, 16'hFFFF);
    send(CMD_NONE, 3'd7, 10'h3FF, 16'hFFFF);
    send(CMD_STEP, 3'd0, 10'd0, 16'h0000);
    send(CMD_ZERO, 3'd0, 10'd0, 16'h0000);
    send(CMD_STEP, 3'd0, 10'd0, 16'h0000);

    // Zero arm count behaves as one, origin at the corner.
    configure(0, 0, 0);
    send(CMD_LOAD, 3'd0, 10'd1023, 16'h8000);
    send(CMD_STEP, 3'd0, 10'd0, 16'h0000);
    send(CMD_STEP, 3'd0, 10'd0, 16'h0000);

    // Arm count above the chain size behaves as the full chain.
    configure(15, 4095, 4095);
    send(CMD_LOAD, 3'd0, 10'd1023, 16'h7FFF);
    send(CMD_LOAD, 3'd1, 10'd1023, 16'h8000);
    send(CMD_LOAD, 3'd2, 10'd1023, 16'h0001);
    send(CMD_LOAD, 3'd3, 10'd1023, 16'hFFFF);
    send(CMD_LOAD, 3'd4, 10'd1023, 16'h2000);
    send(CMD_LOAD, 3'd5, 10'd1023, 16'hE000);
    send(CMD_LOAD, 3'd6, 10'd512, 16'h0400);
    send(CMD_LOAD, 3'd7, 10'd1023, 16'hC000);
    repeat (3) send(CMD_STEP, 3'd0, 10'd0, 16'h0000);

    // Random part: each phase sets the registers, loads the whole chain, then runs.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: count = 8;
        1: count = 1;
        2: count = 0;
        3: count = 15;
        default: count = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
      endcase
      r  = $urandom_range(3);
      cx = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(4095);
      r  = $urandom_range(3);
      cy = (r == 0) ? 4095 : (r == 1) ? 0 : $urandom_range(4095);
      configure(count, cx, cy);
      calm = (ph % 3 == 2);
      for (int a = 0; a < MAX_ARMS; a++) begin
        send(CMD_LOAD, 3'(a), pick_length(), pick_step());
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        // At the middle of each phase the sender holds off until all points are out.
        if (done == PHASE_ITEMS / 2) begin
          drain();
        end
        r = $urandom_range(99);
        if (r < 72) begin
          send(CMD_STEP, 3'($urandom_range(7)), 10'($urandom_range(1023)),
               STEP_W'($urandom_range(16'hFFFF)));
        end else if (r < 86) begin
          send(CMD_LOAD, 3'($urandom_range(7)), pick_length(), pick_step());
        end else if (r < 92) begin
          send(CMD_ZERO, 3'($urandom_range(7)), 10'($urandom_range(1023)),
               STEP_W'($urandom_range(16'hFFFF)));
        end else begin
          send(CMD_NONE, 3'($urandom_range(7)), 10'($urandom_range(1023)),
               STEP_W'($urandom_range(16'hFFFF)));
          done = done - 1;
        end
        done = done + 1;
      end
      calm = 1'b0;
    end

    // Wait for the last points, then let the block settle.
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d register settings: %0d loads, %0d steps, %0d phase clears, %0d ignored.",
             settings_used, sb.cmd_seen[CMD_LOAD], sb.cmd_seen[CMD_STEP],
             sb.cmd_seen[CMD_ZERO], sb.cmd_seen[CMD_NONE]);
    $display("Checked %0d tip points with %0d field errors.", sb.points_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("chained_phasor_point_generator_core: match");
    end else begin
      $display("chained_phasor_point_generator_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== chained_phasor_point_generator_core.f =====
rtl/cpg_pkg.sv
rtl/cpg_cordic_cell.sv
rtl/cpg_tip_accum.sv
rtl/chained_phasor_point_generator_core.sv
verif/tb_chained_phasor_point_generator_core.sv
